[rtl/tonp_pkg.sv]
// Shared types, constants and helper functions for the telnet option negotiator.
// No dependencies; every other file of the block but tonp_if.sv refers to it by scoped names.
package tonp_pkg;

  // Telnet protocol bytes.
  localparam logic [7:0] IAC_BYTE  = 8'hFF;
  localparam logic [7:0] VERB_WILL = 8'd251;
  localparam logic [7:0] VERB_WONT = 8'd252;
  localparam logic [7:0] VERB_DO   = 8'd253;
  localparam logic [7:0] VERB_DONT = 8'd254;
  localparam logic [7:0] OPT_ECHO  = 8'h01;
  localparam logic [7:0] OPT_SGA   = 8'h03;
  localparam logic [7:0] CMD_LOW   = 8'd240;
  localparam logic [7:0] CMD_HIGH  = 8'd250;

  // Destination codes carried in out_kind.
  localparam logic KIND_APP  = 1'b0;
  localparam logic KIND_PEER = 1'b1;

  // Input mode codes.
  localparam logic MODE_DATA = 1'b0;
  localparam logic MODE_CONN = 1'b1;

  // Kind of output run produced by one input word.
  typedef enum logic [1:0] {
    RUN_DATA  = 2'd0,
    RUN_REPLY = 2'd1,
    RUN_GREET = 2'd2
  } run_kind_t;

  // One output run: a data character, a three-byte reply or the greeting.
  typedef struct packed {
    run_kind_t  kind;
    logic [7:0] verb;
    logic [7:0] value;
  } run_t;

  // Index of the last word of a run.
  function automatic logic [2:0] run_last_idx(input run_kind_t kind);
    logic [2:0] idx;
    unique case (kind)
      RUN_REPLY: idx = 3'd2;
      RUN_GREET: idx = 3'd5;
      default:   idx = 3'd0;
    endcase
    return idx;
  endfunction

  // Greeting sent on a new connection: IAC WILL ECHO IAC DO SGA.
  function automatic logic [7:0] greet_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = IAC_BYTE;
      3'd1:    b = VERB_WILL;
      3'd2:    b = OPT_ECHO;
      3'd3:    b = IAC_BYTE;
      3'd4:    b = VERB_DO;
      default: b = OPT_SGA;
    endcase
    return b;
  endfunction

endpackage

[rtl/tonp_if.sv]
// Valid/ready channel interfaces for the input and result words.
// Depends on nothing but the payload widths of the block.
interface tonp_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface tonp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_kind;
  logic       last_of_run;

  modport source (output valid, output out_byte, output out_kind, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_byte, input out_kind, input last_of_run,
                  output ready);
endinterface

[rtl/tonp_parse.sv]
// Telnet command parser: holds the parse state and, while words are accepted, decodes
// one word per cycle into an output run where one is due. Depends on tonp_pkg.
module tonp_parse (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic          mode,
  input  logic [7:0]    data_byte,
  output logic          run_valid,
  output tonp_pkg::run_t run
);

  typedef enum logic [1:0] {
    PH_DATA = 2'd0,
    PH_CMD  = 2'd1,
    PH_OPT  = 2'd2
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] pending_verb, pending_verb_next;
  logic       echo_out, echo_out_next;
  logic       sga_out, sga_out_next;

  // Decode the word against the current parse state.
  always_comb begin
    phase_next        = phase;
    pending_verb_next = pending_verb;
    echo_out_next     = echo_out;
    sga_out_next      = sga_out;
    run_valid         = 1'b0;
    run.kind          = tonp_pkg::RUN_DATA;
    run.verb          = pending_verb;
    run.value         = data_byte;

    if (mode == tonp_pkg::MODE_CONN) begin
      run_valid     = 1'b1;
      run.kind      = tonp_pkg::RUN_GREET;
      echo_out_next = 1'b1;
      sga_out_next  = 1'b1;
      phase_next    = PH_DATA;
    end else begin
      unique case (phase)
        PH_CMD: begin
          if (data_byte >= tonp_pkg::CMD_LOW && data_byte <= tonp_pkg::CMD_HIGH) begin
            phase_next = PH_DATA;
          end else if (data_byte >= tonp_pkg::VERB_WILL &&
                       data_byte <= tonp_pkg::VERB_DONT) begin
            pending_verb_next = data_byte;
            phase_next        = PH_OPT;
          end else if (data_byte != tonp_pkg::IAC_BYTE) begin
            phase_next = PH_DATA;
            run_valid  = 1'b1;
          end
        end
        PH_OPT: begin
          phase_next = PH_DATA;
          run.kind   = tonp_pkg::RUN_REPLY;
          if (pending_verb == tonp_pkg::VERB_WILL) begin
            if (data_byte == tonp_pkg::OPT_SGA) begin
              if (sga_out) begin
                sga_out_next = 1'b0;
              end else begin
                run_valid = 1'b1;
                run.verb  = tonp_pkg::VERB_DO;
              end
            end else begin
              run_valid = 1'b1;
              run.verb  = tonp_pkg::VERB_DONT;
            end
          end else if (pending_verb == tonp_pkg::VERB_DO) begin
            if (data_byte == tonp_pkg::OPT_ECHO && echo_out) begin
              echo_out_next = 1'b0;
            end else if (data_byte == tonp_pkg::OPT_ECHO ||
                         data_byte == tonp_pkg::OPT_SGA) begin
              run_valid = 1'b1;
              run.verb  = tonp_pkg::VERB_WILL;
            end else begin
              run_valid = 1'b1;
              run.verb  = tonp_pkg::VERB_WONT;
            end
          end
        end
        default: begin
          // Data phase; the unused phase code behaves the same way.
          if (data_byte == tonp_pkg::IAC_BYTE) begin
            phase_next = PH_CMD;
          end else begin
            phase_next = PH_DATA;
            run_valid  = 1'b1;
          end
        end
      endcase
    end
  end

  // Parse state advances only on an accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_DATA;
      pending_verb <= '0;
      echo_out     <= 1'b0;
      sga_out      <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      pending_verb <= pending_verb_next;
      echo_out     <= echo_out_next;
      sga_out      <= sga_out_next;
    end
  end

endmodule

[rtl/tonp_emit.sv]
// Run queue and output stage: a pending-run register feeds the current run,
// which is sent one word per handshake. Depends on tonp_pkg.
module tonp_emit (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  tonp_pkg::run_t load_run,
  output logic           can_load,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           out_kind,
  output logic           out_last
);

  logic           pend_valid;
  tonp_pkg::run_t pend;
  logic           cur_valid;
  tonp_pkg::run_t cur;
  logic [2:0]     idx;
  logic           cur_done;

  // The current run is finished when empty or its last word is taken.
  assign out_last  = (idx == tonp_pkg::run_last_idx(cur.kind));
  assign cur_done  = !cur_valid || (out_ready && out_last);
  assign can_load  = !pend_valid || cur_done;
  assign out_valid = cur_valid;

  // Select the word of the current run at the current index.
  always_comb begin
    out_kind = tonp_pkg::KIND_PEER;
    unique case (cur.kind)
      tonp_pkg::RUN_GREET: out_byte = tonp_pkg::greet_byte(idx);
      tonp_pkg::RUN_REPLY: begin
        if (idx == 3'd0) begin
          out_byte = tonp_pkg::IAC_BYTE;
        end else if (idx == 3'd1) begin
          out_byte = cur.verb;
        end else begin
          out_byte = cur.value;
        end
      end
      default: begin
        out_byte = cur.value;
        out_kind = tonp_pkg::KIND_APP;
      end
    endcase
  end

  // Control of the pending register and the current run.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      cur_valid  <= 1'b0;
      idx        <= '0;
    end else begin
      if (load) begin
        pend_valid <= 1'b1;
      end else if (cur_done) begin
        pend_valid <= 1'b0;
      end
      if (cur_done) begin
        cur_valid <= pend_valid;
        idx       <= '0;
      end else if (out_ready) begin
        idx <= idx + 3'd1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (load) begin
      pend <= load_run;
    end
    if (cur_done) begin
      cur <= pend;
    end
  end

endmodule

[rtl/telnet_option_negotiator.sv]
// Telnet option negotiator top level: parser plus run queue and output stage.
// The first result word is registered in the pending-run register and then in the current-run
// register before it is offered on the output.
// Throughput: 1 input word per cycle while each produces at most one word and the output is not stalled;
// otherwise input pace follows the output, one word per cycle (3 per reply, 6 per greeting).
// Reset (rst, synchronous): parse state and both offer flags clear, queue empties.
module telnet_option_negotiator (
  input  logic       clk,
  input  logic       rst,
  tonp_in_if.sink    in_ch,
  tonp_out_if.source out_ch
);

  logic           accept;
  logic           can_load;
  logic           run_valid;
  tonp_pkg::run_t run;

  assign in_ch.ready = can_load;
  assign accept      = in_ch.valid && can_load;

  // Parser.
  tonp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .mode      (in_ch.mode),
    .data_byte (in_ch.data_byte),
    .run_valid (run_valid),
    .run       (run)
  );

  // Run queue and output stage.
  tonp_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && run_valid),
    .load_run  (run),
    .can_load  (can_load),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .out_kind  (out_ch.out_kind),
    .out_last  (out_ch.last_of_run)
  );

endmodule

[rtl/tonp_check.sv]
// Port-level checks for the telnet option negotiator, bound to the top level.
// Depends on tonp_pkg and the top level's channel ports.
module tonp_check (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_kind,
  input logic       out_last
);

  logic run_start;

  // Tracks whether the next result word opens a new run.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_start <= 1'b1;
    end else if (out_valid && out_ready) begin
      run_start <= out_last;
    end
  end

  // No result word is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word offered after reset");

  // Characters for the application always come one to a run.
  a_data_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == tonp_pkg::KIND_APP) |-> out_last)
    else $error("application character not marked as last of run");

  // Every run toward the peer opens with IAC.
  a_peer_iac: assert property (@(posedge clk) disable iff (rst)
    (out_valid && run_start && out_kind == tonp_pkg::KIND_PEER)
      |-> out_byte == tonp_pkg::IAC_BYTE)
    else $error("peer run does not open with IAC");

  // A stalled word stays offered and unchanged.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_byte) && $stable(out_kind)))
    else $error("stalled result word changed");

endmodule

bind telnet_option_negotiator tonp_check u_check (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_kind  (out_ch.out_kind),
  .out_last  (out_ch.last_of_run)
);

[tb/telnet_option_negotiator_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the telnet option negotiator. It watches both channels, predicts every
// result word from its own model of the parser and compares the words field by field.
// Depends on tonp_pkg and on the channel interfaces in tonp_if.sv.
module telnet_option_negotiator_checker (
  input  logic clk,
  input  logic rst,
  tonp_in_if   in_ch,
  tonp_out_if  out_ch,
  output int   fail_count,
  output int   pending
);

  typedef enum logic [1:0] {
    PH_DATA = 2'd0,
    PH_CMD  = 2'd1,
    PH_OPT  = 2'd2
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_kind;
    logic       last_of_run;
  } result_word_t;

  // Result words predicted but not yet seen on the output channel, oldest first.
  result_word_t expected_words[$];

  // Parser state as the block should hold it.
  parse_phase_t phase_q;
  logic [7:0]   verb_q;
  logic         echo_offer_q;
  logic         sga_request_q;

  function automatic void push_word(input logic [7:0] b, input logic kind, input logic last);
    result_word_t w;
    w.out_byte    = b;
    w.out_kind    = kind;
    w.last_of_run = last;
    expected_words.push_back(w);
  endfunction

  // A reply to the peer is always IAC, verb, option.
  function automatic void push_reply(input logic [7:0] verb, input logic [7:0] opt);
    push_word(tonp_pkg::IAC_BYTE, tonp_pkg::KIND_PEER, 1'b0);
    push_word(verb, tonp_pkg::KIND_PEER, 1'b0);
    push_word(opt, tonp_pkg::KIND_PEER, 1'b1);
  endfunction

  // Advance the parser by one accepted input word and queue the words it causes.
  function automatic void negotiate_byte(input logic mode, input logic [7:0] c);
    if (mode == tonp_pkg::MODE_CONN) begin
      // New connection: greeting offers ECHO and requests SGA.
      push_word(tonp_pkg::IAC_BYTE, tonp_pkg::KIND_PEER, 1'b0);
      push_word(tonp_pkg::VERB_WILL, tonp_pkg::KIND_PEER, 1'b0);
      push_word(tonp_pkg::OPT_ECHO, tonp_pkg::KIND_PEER, 1'b0);
      push_word(tonp_pkg::IAC_BYTE, tonp_pkg::KIND_PEER, 1'b0);
      push_word(tonp_pkg::VERB_DO, tonp_pkg::KIND_PEER, 1'b0);
      push_word(tonp_pkg::OPT_SGA, tonp_pkg::KIND_PEER, 1'b1);
      echo_offer_q  = 1'b1;
      sga_request_q = 1'b1;
      phase_q       = PH_DATA;
    end else begin
      case (phase_q)
        PH_CMD: begin
          if (c >= tonp_pkg::CMD_LOW && c <= tonp_pkg::CMD_HIGH) begin
            phase_q = PH_DATA;
          end else if (c >= tonp_pkg::VERB_WILL && c <= tonp_pkg::VERB_DONT) begin
            verb_q  = c;
            phase_q = PH_OPT;
          end else if (c != tonp_pkg::IAC_BYTE) begin
            // Unknown command byte goes to the application as a character.
            phase_q = PH_DATA;
            push_word(c, tonp_pkg::KIND_APP, 1'b1);
          end
        end
        PH_OPT: begin
          phase_q = PH_DATA;
          if (verb_q == tonp_pkg::VERB_WILL) begin
            if (c == tonp_pkg::OPT_SGA) begin
              // The first WILL SGA answers our own request and gets no reply.
              if (sga_request_q) sga_request_q = 1'b0;
              else push_reply(tonp_pkg::VERB_DO, c);
            end else begin
              push_reply(tonp_pkg::VERB_DONT, c);
            end
          end else if (verb_q == tonp_pkg::VERB_DO) begin
            if (c == tonp_pkg::OPT_ECHO) begin
              if (echo_offer_q) echo_offer_q = 1'b0;
              else push_reply(tonp_pkg::VERB_WILL, c);
            end else if (c == tonp_pkg::OPT_SGA) begin
              push_reply(tonp_pkg::VERB_WILL, c);
            end else begin
              push_reply(tonp_pkg::VERB_WONT, c);
            end
          end
        end
        default: begin
          if (c == tonp_pkg::IAC_BYTE) phase_q = PH_CMD;
          else push_word(c, tonp_pkg::KIND_APP, 1'b1);
        end
      endcase
    end
  endfunction

  // Compare each accepted result word, then predict from the accepted input word.
  always @(posedge clk) begin
    result_word_t exp_w;
    if (rst) begin
      phase_q       = PH_DATA;
      verb_q        = 8'd0;
      echo_offer_q  = 1'b0;
      sga_request_q = 1'b0;
      fail_count    = 0;
      expected_words.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word: out_byte %0d, out_kind %0d, last_of_run %0d",
                 out_ch.out_byte, out_ch.out_kind, out_ch.last_of_run);
          fail_count++;
        end else begin
          exp_w = expected_words.pop_front();
          if (out_ch.out_byte !== exp_w.out_byte) begin
            $error("out_byte: expected %0d, actual %0d", exp_w.out_byte, out_ch.out_byte);
            fail_count++;
          end
          if (out_ch.out_kind !== exp_w.out_kind) begin
            $error("out_kind: expected %0d, actual %0d", exp_w.out_kind, out_ch.out_kind);
            fail_count++;
          end
          if (out_ch.last_of_run !== exp_w.last_of_run) begin
            $error("last_of_run: expected %0d, actual %0d",
                   exp_w.last_of_run, out_ch.last_of_run);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) negotiate_byte(in_ch.mode, in_ch.data_byte);
    end
    pending <= expected_words.size();
  end

endmodule

[tb/telnet_option_negotiator_tb.sv]
`timescale 1ns / 1ps
// Top of the telnet option negotiator testbench: clock, reset, byte stimulus and verdict.
// Depends on tonp_pkg, tonp_if.sv, the block and telnet_option_negotiator_checker.
module telnet_option_negotiator_tb;

  localparam int RANDOM_WORDS = 450;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;

  logic clk;
  logic rst;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   cycle_count = 0;
  int   sent_words = 0;
  int   fail_count;
  int   pending;

  tonp_in_if  in_ch ();
  tonp_out_if out_ch ();

  telnet_option_negotiator DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  telnet_option_negotiator_checker word_checker (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver side: stall at random at the rate of the current phase.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one word, with random idle cycles first, and wait until it is taken.
  task automatic send_word(input logic mode, input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= mode;
    in_ch.data_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_words++;
  endtask

  task automatic send_option(input logic [7:0] verb, input logic [7:0] opt);
    send_word(tonp_pkg::MODE_DATA, tonp_pkg::IAC_BYTE);
    send_word(tonp_pkg::MODE_DATA, verb);
    send_word(tonp_pkg::MODE_DATA, opt);
  endtask

  // Mostly well-formed telnet traffic, with some raw noise bytes mixed in.
  task automatic send_random(input int count);
    int         target;
    int         pick;
    int         opt_pick;
    logic [7:0] verb;
    logic [7:0] opt;
    target = sent_words + count;
    while (sent_words < target) begin
      pick = int'($urandom_range(99));
      if (pick < 5) begin
        send_word(tonp_pkg::MODE_CONN, 8'($urandom_range(255)));
      end else if (pick < 30) begin
        send_word(tonp_pkg::MODE_DATA, 8'($urandom_range(254)));
      end else if (pick < 65) begin
        verb     = tonp_pkg::VERB_WILL + 8'($urandom_range(3));
        opt_pick = int'($urandom_range(99));
        if (opt_pick < 35) opt = tonp_pkg::OPT_ECHO;
        else if (opt_pick < 70) opt = tonp_pkg::OPT_SGA;
        else opt = 8'($urandom_range(255));
        send_option(verb, opt);
      end else if (pick < 75) begin
        send_word(tonp_pkg::MODE_DATA, tonp_pkg::IAC_BYTE);
        if ($urandom_range(3) == 0) send_word(tonp_pkg::MODE_DATA, tonp_pkg::IAC_BYTE);
        send_word(tonp_pkg::MODE_DATA, tonp_pkg::CMD_LOW + 8'($urandom_range(10)));
      end else if (pick < 82) begin
        send_word(tonp_pkg::MODE_DATA, tonp_pkg::IAC_BYTE);
        send_word(tonp_pkg::MODE_DATA, 8'($urandom_range(239)));
      end else begin
        send_word(tonp_pkg::MODE_DATA, 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.mode      <= tonp_pkg::MODE_DATA;
    in_ch.data_byte <= 8'd0;
    rst             <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed traffic: greeting, plain bytes, dropped commands and every verb.
    send_word(tonp_pkg::MODE_CONN, 8'hA5);
    send_word(tonp_pkg::MODE_DATA, 8'h00);
    send_word(tonp_pkg::MODE_DATA, 8'hFE);
    send_word(tonp_pkg::MODE_DATA, tonp_pkg::IAC_BYTE);
    send_word(tonp_pkg::MODE_DATA, tonp_pkg::IAC_BYTE);
    send_word(tonp_pkg::MODE_DATA, tonp_pkg::CMD_LOW);
    send_word(tonp_pkg::MODE_DATA, tonp_pkg::IAC_BYTE);
    send_word(tonp_pkg::MODE_DATA, 8'd239);
    send_option(tonp_pkg::VERB_WILL, tonp_pkg::OPT_SGA);
    send_option(tonp_pkg::VERB_WILL, tonp_pkg::OPT_SGA);
    send_option(tonp_pkg::VERB_DO, tonp_pkg::OPT_ECHO);
    send_option(tonp_pkg::VERB_DO, tonp_pkg::OPT_ECHO);
    send_option(tonp_pkg::VERB_DO, tonp_pkg::OPT_SGA);
    send_option(tonp_pkg::VERB_WILL, 8'hFF);
    send_option(tonp_pkg::VERB_DONT, 8'h80);
    // A new connection in the middle of a negotiation restarts the parse.
    send_word(tonp_pkg::MODE_DATA, tonp_pkg::IAC_BYTE);
    send_word(tonp_pkg::MODE_DATA, tonp_pkg::VERB_WONT);
    send_word(tonp_pkg::MODE_CONN, 8'h5A);
    send_word(tonp_pkg::MODE_DATA, tonp_pkg::CMD_HIGH);

    // Random traffic under each idling pattern in turn.
    send_random(RANDOM_WORDS / 4);
    idle_pct = 49;
    send_random(RANDOM_WORDS / 4);
    idle_pct  = 0;
    stall_pct = 49;
    send_random(RANDOM_WORDS / 4);
    idle_pct  = 21;
    stall_pct = 21;
    send_random(RANDOM_WORDS / 4);

    // Drain everything still expected, then watch for stray words.
    in_ch.valid <= 1'b0;
    stall_pct = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/tonp_pkg.sv
rtl/tonp_if.sv
rtl/tonp_parse.sv
rtl/tonp_emit.sv
rtl/telnet_option_negotiator.sv
rtl/tonp_check.sv
tb/telnet_option_negotiator_checker.sv
tb/telnet_option_negotiator_tb.sv
